### sv/date_add_days_defines.svh
// assertion macros shared by the date adder
`ifndef DATE_ADD_DAYS_DEFINES_SVH
`define DATE_ADD_DAYS_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define DAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("date_add_days check failed");

// next-cycle implication, sampled on clk, off during rst
`define DAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("date_add_days check failed");

`endif

### sv/dad_pkg.sv
package dad_pkg;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_REM,
    ST_WALK,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic rem;
    logic step;
  } dad_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic walk_last;
  } dad_status_t;

  // month lengths of a common year, january first
  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [4:0] LEAP_FEB_DAYS = 5'd29;
  localparam logic [4:0] ODD_MONTH_DAYS = 5'd31;
  localparam logic [3:0] MONTHS_PER_YEAR = 4'd12;
  localparam logic [3:0] FEBRUARY = 4'd2;
  localparam logic [3:0] JANUARY = 4'd1;

  // year mod 400 via reciprocal: q = (yr * DIV400_MUL) >> DIV400_SHIFT
  localparam int unsigned YEAR_CYCLE = 400;
  localparam logic [16:0] DIV400_MUL = 17'd83887;
  localparam int unsigned DIV400_SHIFT = 25;
  localparam logic [8:0] YEAR_CYCLE_LAST = 9'(YEAR_CYCLE - 1);

  // month length, months outside 1..12 count 31 days
  function automatic logic [4:0] month_length(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    len = ODD_MONTH_DAYS;
    if (mon >= JANUARY && mon <= MONTHS_PER_YEAR) begin
      len = MONTH_DAYS[4'(mon - JANUARY)];
      if (mon == FEBRUARY && leap) begin
        len = LEAP_FEB_DAYS;
      end
    end
    return len;
  endfunction

endpackage

### sv/dad_ctrl.sv
module dad_ctrl
  import dad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  dad_status_t status,
  output dad_cmd_t    cmd,
  output logic        busy,
  output logic        done
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        state_next = ST_REM;
      end
      ST_REM: begin
        cmd.rem = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        cmd.step = 1'b1;
        if (status.walk_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        done = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/dad_dp.sv
module dad_dp
  import dad_pkg::*;
(
  input  logic        clk,
  input  dad_cmd_t    cmd,
  input  logic [4:0]  start_day,
  input  logic [3:0]  start_month,
  input  logic [15:0] start_year,
  input  logic [15:0] days_to_add,
  output dad_status_t status,
  output logic [4:0]  result_day,
  output logic [3:0]  result_month,
  output logic [15:0] result_year,
  output logic        year_overflow
);

  logic [4:0]  day;
  logic [3:0]  mon;
  logic [15:0] yr;
  logic [16:0] left;
  logic        wrapped;
  logic [7:0]  quot;
  logic [8:0]  r400;

  logic [32:0] quot_prod;
  logic [16:0] cycle_prod;
  logic        century;
  logic        leap;
  logic [4:0]  len;
  logic [17:0] day_sum;
  logic [17:0] rest;
  logic        fits;

  // year / 400 from the start year
  assign quot_prod = 33'(start_year) * 33'(DIV400_MUL);
  assign cycle_prod = 17'(quot) * 17'(YEAR_CYCLE);

  // leap year from the low year bits and the year mod 400
  always_comb begin
    century = r400 inside {9'd0, 9'd100, 9'd200, 9'd300};
    leap = (r400 == 9'd0) || ((yr[1:0] == 2'b00) && !century);
  end

  // one month step
  assign len = month_length(mon, leap);
  assign day_sum = 18'(day) + 18'(left);
  assign fits = day_sum <= 18'(len);
  assign rest = day_sum - 18'(len) - 18'd1;
  assign status.walk_last = (left == 17'd0) || fits;

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      day <= start_day;
      mon <= start_month;
      yr <= start_year;
      left <= 17'(days_to_add);
      wrapped <= 1'b0;
      quot <= quot_prod[DIV400_SHIFT +: 8];
    end else if (cmd.rem) begin
      r400 <= 9'(17'(yr) - cycle_prod);
    end else if (cmd.step && left != 17'd0) begin
      if (fits) begin
        day <= 5'(day_sum);
        left <= 17'd0;
      end else begin
        left <= rest[16:0];
        day <= 5'd1;
        if (mon >= MONTHS_PER_YEAR) begin
          mon <= JANUARY;
          if (yr == 16'hFFFF) begin
            yr <= 16'd0;
            r400 <= 9'd0;
            wrapped <= 1'b1;
          end else begin
            yr <= yr + 16'd1;
            r400 <= (r400 == YEAR_CYCLE_LAST) ? 9'd0 : r400 + 9'd1;
          end
        end else begin
          mon <= mon + 4'd1;
        end
      end
    end
  end

  // results straight from the registers
  assign result_day = day;
  assign result_month = mon;
  assign result_year = yr;
  assign year_overflow = wrapped;

endmodule

### sv/date_add_days.sv
// date_add_days: adds a day count to a gregorian date
//
// command channel: drive start_day, start_month, start_year and days_to_add
// with start high; the word is taken at a rising edge where busy is low.
// busy stays high until the result has been shown.
// result channel: done is high for exactly one cycle with result_day,
// result_month, result_year and year_overflow valid in that cycle. the
// receiver cannot stall; it must take the word when done is high.
// sequence: the accept cycle loads the date and forms year / 400 by a
// reciprocal multiply, a spare state follows, then year mod 400, then one
// month stepped per cycle (at least one), then the done cycle; the next word
// can be taken in the cycle after done. the month walk dominates the time a
// word takes: up to about 2160 months for a count of 65535. a year stepped
// past 65535 wraps to 0 and sets year_overflow.
// reset: rst is synchronous and returns the controller to idle; a word in
// flight is dropped with no result. the datapath registers are not cleared.
module date_add_days
  import dad_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  start_day,
  input  logic [3:0]  start_month,
  input  logic [15:0] start_year,
  input  logic [15:0] days_to_add,
  output logic        done,
  output logic [4:0]  result_day,
  output logic [3:0]  result_month,
  output logic [15:0] result_year,
  output logic        year_overflow
);

`include "date_add_days_defines.svh"

  dad_cmd_t    cmd;
  dad_status_t status;

  // sequencer
  dad_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // date registers and month stepper
  dad_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .start_day     (start_day),
    .start_month   (start_month),
    .start_year    (start_year),
    .days_to_add   (days_to_add),
    .status        (status),
    .result_day    (result_day),
    .result_month  (result_month),
    .result_year   (result_year),
    .year_overflow (year_overflow)
  );

  // a result only shows while a command is in flight
  `DAD_ASSERT_NOW(a_done_busy, done, busy)
  // an accepted command makes the block busy
  `DAD_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done)
  // one strobe per command
  `DAD_ASSERT_NEXT(a_done_single, done, !done && !busy)

endmodule

### tb/tb_date_add_days.sv
`timescale 1ns / 100ps

module tb_date_add_days;

  // one result word of the date adder
  typedef struct {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [15:0] year;
    logic        ovf;
  } date_word_t;

  // expected dates, one per accepted command word
  class date_scoreboard;
    date_word_t due_dates[$];
    int unsigned errors;

    // days in a month, months outside 1..12 have 31
    function int month_days(int unsigned mon, int unsigned yr);
      bit leap;
      leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
      case (mon)
        1, 3, 5, 7, 8, 10, 12: return 31;
        4, 6, 9, 11: return 30;
        2: return leap ? 29 : 28;
        default: return 31;
      endcase
    endfunction

    // month-by-month walk from the start date
    function date_word_t walk_calendar(logic [4:0] d, logic [3:0] m, logic [15:0] y,
                                       logic [15:0] n);
      date_word_t res;
      int day;
      int left;
      int len;
      int unsigned mon;
      int unsigned yr;
      bit wrapped;
      day = d;
      mon = m;
      yr = y;
      left = n;
      wrapped = 0;
      while (left > 0) begin
        len = month_days(mon, yr);
        if (day + left <= len) begin
          day += left;
          left = 0;
        end else begin
          left -= (len - day + 1);
          day = 1;
          mon++;
          if (mon > 12) begin
            mon = 1;
            if (yr == 65535) begin
              yr = 0;
              wrapped = 1;
            end else begin
              yr++;
            end
          end
        end
      end
      res.day = 5'(day);
      res.month = 4'(mon);
      res.year = 16'(yr);
      res.ovf = wrapped;
      return res;
    endfunction

    function void note_command(logic [4:0] d, logic [3:0] m, logic [15:0] y, logic [15:0] n);
      due_dates.push_back(walk_calendar(d, m, y, n));
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_word(date_word_t got);
      date_word_t want;
      if (due_dates.size() == 0) begin
        report_mismatch("unexpected result word", 1, 0);
        return;
      end
      want = due_dates.pop_front();
      if (got.day !== want.day) report_mismatch("result_day", got.day, want.day);
      if (got.month !== want.month) report_mismatch("result_month", got.month, want.month);
      if (got.year !== want.year) report_mismatch("result_year", got.year, want.year);
      if (got.ovf !== want.ovf) report_mismatch("year_overflow", got.ovf, want.ovf);
    endtask

    function int pending();
      return due_dates.size();
    endfunction

    task close_out();
      if (due_dates.size() != 0) report_mismatch("missing result words", 0, due_dates.size());
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [4:0]  start_day;
  logic [3:0]  start_month;
  logic [15:0] start_year;
  logic [15:0] days_to_add;
  logic        done;
  logic [4:0]  result_day;
  logic [3:0]  result_month;
  logic [15:0] result_year;
  logic        year_overflow;

  date_scoreboard sb = new();
  int unsigned words_taken = 0;
  int unsigned idle_pct = 0;

  date_add_days u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .start_day    (start_day),
    .start_month  (start_month),
    .start_year   (start_year),
    .days_to_add  (days_to_add),
    .done         (done),
    .result_day   (result_day),
    .result_month (result_month),
    .result_year  (result_year),
    .year_overflow(year_overflow)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    date_word_t got;
    if (!rst) begin
      if (start && !busy) begin
        sb.note_command(start_day, start_month, start_year, days_to_add);
        words_taken++;
      end
      if (done) begin
        got.day = result_day;
        got.month = result_month;
        got.year = result_year;
        got.ovf = year_overflow;
        sb.check_word(got);
      end
    end
  end

  // present one command word, held until it is taken
  task automatic send_date(input int d, input int m, input int y, input int n);
    int unsigned taken_before;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      start_day = 5'($urandom);
      start_month = 4'($urandom);
      start_year = 16'($urandom);
      days_to_add = 16'($urandom);
      @(negedge clk);
    end
    taken_before = words_taken;
    start = 1'b1;
    start_day = 5'(d);
    start_month = 4'(m);
    start_year = 16'(y);
    days_to_add = 16'(n);
    while (words_taken == taken_before) @(negedge clk);
  endtask

  // mostly proper dates, some out-of-range day and month words
  task automatic send_random_date();
    int d;
    int m;
    int y;
    int n;
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) y = 65535 - $urandom_range(3);
    else if (sel == 1) y = 100 * $urandom_range(655);
    else y = $urandom_range(65535);
    if ($urandom_range(99) < 85) begin
      m = $urandom_range(12, 1);
      d = $urandom_range(sb.month_days(m, y), 1);
    end else begin
      m = $urandom_range(15);
      d = $urandom_range(31);
    end
    sel = $urandom_range(99);
    if (sel < 5) n = 0;
    else if (sel < 65) n = $urandom_range(1000);
    else if (sel < 90) n = $urandom_range(65535);
    else n = 60000 + $urandom_range(5535);
    send_date(d, m, y, n);
  endtask

  // hold off until every expected word is back
  task automatic drain_results();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // stimulus
  initial begin
    rst = 1'b1;
    start = 1'b0;
    start_day = '0;
    start_month = '0;
    start_year = '0;
    days_to_add = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // zero count, proper and odd fields
    send_date(15, 6, 2024, 0);
    send_date(0, 0, 0, 0);
    send_date(31, 15, 65535, 0);
    // leap rules around february
    send_date(28, 2, 2000, 1);
    send_date(28, 2, 1900, 1);
    send_date(28, 2, 2024, 1);
    send_date(28, 2, 2023, 1);
    send_date(1, 3, 2000, 365);
    // day beyond the month
    send_date(31, 2, 2023, 1);
    send_date(31, 4, 2023, 5);
    // day zero
    send_date(0, 3, 2023, 1);
    send_date(0, 3, 2023, 40);
    // month zero and above twelve
    send_date(10, 0, 1999, 40);
    send_date(5, 13, 1999, 1);
    send_date(31, 15, 1999, 1);
    send_date(31, 15, 65535, 1);
    // year wrap
    send_date(31, 12, 65535, 1);
    send_date(30, 12, 65534, 400);
    // extremes of the count
    send_date(1, 1, 0, 65535);
    send_date(31, 15, 65535, 65535);
    send_date(1, 1, 65535, 65535);
    drain_results();

    // random phases: no idling, sender idle about half, sender idle a fifth
    idle_pct = 0;
    repeat (83) send_random_date();
    drain_results();
    idle_pct = 51;
    repeat (83) send_random_date();
    drain_results();
    idle_pct = 20;
    repeat (83) send_random_date();
    drain_results();

    repeat (40) @(negedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
